/* hw/rtl/mts_pkg.sv */
// Shared types and constants for the minimum-tracking stack.
package mts_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned EntryW        = 34;
  localparam int unsigned CountOutW     = 9;
  localparam int unsigned StackDepthDef = 256;

  typedef logic signed [DataW-1:0]  data_t;
  typedef logic signed [EntryW-1:0] entry_t;

  typedef enum logic [1:0] {
    OpPush = 2'd0,
    OpPop  = 2'd1,
    OpTop  = 2'd2,
    OpMin  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

/* hw/rtl/mts_cell.sv */
// One stack position: takes the entry above it on a push and the one below it on a pop.
module mts_cell (
  input  logic            clk_i,
  input  mts_pkg::shift_t shift_i,
  input  mts_pkg::entry_t from_prev_i,
  input  mts_pkg::entry_t from_next_i,
  output mts_pkg::entry_t entry_o
);

  mts_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      entry_q <= from_prev_i;
    end else if (shift_i.pop) begin
      entry_q <= from_next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

/* hw/rtl/min_tracking_stack_core.sv */
// Top level of the minimum-tracking stack built as a row of shifting cells.
//
// The input stream carries one operation per word: tuser holds the opcode
// (push, pop, read top, read minimum) and tdata the signed value to push.
// The output stream returns one word per operation: tdata holds the result
// value, the empty flag and the entry count, and tuser holds the status.
// Entries live in a row of cells; the top of stack always sits in the first
// cell, and a push or pop moves every cell one place together.
// The running minimum is kept in a register, and entries pushed below it are
// stored in an encoded form from which a pop recovers the previous minimum.
// The result is registered and is output in the cycle after acceptance.
// Throughput is one word per cycle while the receiver keeps up, set by the
// row shift and the compare and subtract on the first cell and the minimum.
// Reset clears the entry count, the minimum and the output valid flag; the
// cell contents are not cleared and are never read before being written.
// When the receiver stalls, the result stays in the output register and the
// input side stops accepting until that word is taken.
module min_tracking_stack_core #(
  parameter int unsigned StackDepth = mts_pkg::StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] push_value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [31:0] result_value, [32] now_empty,
                                       // [41:33] entry_count, [47:42] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);

  mts_pkg::entry_t stk_q [StackDepth];
  mts_pkg::shift_t shift;
  mts_pkg::entry_t new_entry;

  logic [CntW-1:0]  count_q, count_d;
  mts_pkg::data_t   min_q, min_d;

  logic             out_valid_q;
  mts_pkg::data_t   out_value_q, out_value_d;
  mts_pkg::status_e out_status_q, out_status_d;
  logic             out_empty_q;
  logic [mts_pkg::CountOutW-1:0] out_count_q;

  logic             accept;
  mts_pkg::op_e     op;
  mts_pkg::entry_t  top_entry, push_ext, min_ext, enc_entry, dec_min;
  logic             is_empty, is_full, below_min, top_gt_min;
  logic [31:0]      count_wide;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = mts_pkg::op_e'(s_axis_tuser_i);

  assign top_entry  = stk_q[0];
  assign push_ext   = mts_pkg::entry_t'($signed(s_axis_tdata_i));
  assign min_ext    = mts_pkg::entry_t'(min_q);
  assign enc_entry  = (push_ext <<< 1) - min_ext;
  assign dec_min    = (min_ext <<< 1) - top_entry;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CntW'(StackDepth));
  assign below_min  = (push_ext < min_ext);
  assign top_gt_min = (top_entry > min_ext);

  always_comb begin
    shift        = '0;
    new_entry    = push_ext;
    count_d      = count_q;
    min_d        = min_q;
    out_value_d  = '0;
    out_status_d = mts_pkg::StOk;
    case (op)
      mts_pkg::OpPush: begin
        if (is_full) begin
          out_status_d = mts_pkg::StFull;
        end else begin
          shift.push = accept;
          count_d    = count_q + 1'b1;
          if (is_empty || below_min) begin
            min_d = $signed(s_axis_tdata_i);
          end
          if (!is_empty && below_min) begin
            new_entry = enc_entry;
          end
        end
      end
      mts_pkg::OpPop: begin
        if (is_empty) begin
          out_status_d = mts_pkg::StEmpty;
        end else begin
          shift.pop = accept;
          count_d   = count_q - 1'b1;
          if (top_gt_min) begin
            out_value_d = top_entry[mts_pkg::DataW-1:0];
          end else begin
            out_value_d = min_q;
            min_d       = dec_min[mts_pkg::DataW-1:0];
          end
        end
      end
      mts_pkg::OpTop: begin
        if (is_empty) begin
          out_status_d = mts_pkg::StEmpty;
        end else if (top_gt_min) begin
          out_value_d = top_entry[mts_pkg::DataW-1:0];
        end else begin
          out_value_d = min_q;
        end
      end
      mts_pkg::OpMin: begin
        if (is_empty) begin
          out_status_d = mts_pkg::StEmpty;
        end else begin
          out_value_d = min_q;
        end
      end
      default: begin
        out_status_d = mts_pkg::StOk;
      end
    endcase
  end

  assign count_wide = 32'(count_d);

  for (genvar i = 0; i < StackDepth; i++) begin : g_stage
    mts_pkg::entry_t from_prev, from_next;
    if (i == 0) begin : g_head
      assign from_prev = new_entry;
    end else begin : g_body
      assign from_prev = stk_q[i-1];
    end
    if (i == StackDepth - 1) begin : g_tail
      assign from_next = '0;
    end else begin : g_link
      assign from_next = stk_q[i+1];
    end
    mts_cell u_stage (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .from_prev_i (from_prev),
      .from_next_i (from_next),
      .entry_o     (stk_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        min_q       <= min_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_empty_q  <= (count_d == '0);
      out_count_q  <= count_wide[mts_pkg::CountOutW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_count_q, out_empty_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(StackDepth))
    else $error("entry count above stack depth");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == mts_pkg::OpPush && !is_full |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted push did not add one entry");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == mts_pkg::StFull |-> is_full)
    else $error("full status reported while stack not full");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != mts_pkg::StOk |-> out_value_q == '0)
    else $error("nonzero result with error status");

endmodule
